/* hdl/nsic_pkg.sv */
// Shared constants for the non-strict inversion counter.
package nsic_pkg;

    localparam int VALUE_W        = 10;
    localparam int TOTAL_W        = 19;
    localparam int IN_DATA_W      = 16;
    localparam int OUT_DATA_W     = 24;
    localparam int EPOCH_BITS     = 4;
    localparam int CAPACITY_DEF   = 1024;
    localparam int VALUE_BITS_DEF = 10;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

endpackage

/* hdl/nsic_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module nsic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/non_strict_inversion_counter.sv */
// Top level of the non-strict inversion counter, a Fenwick tree held in one RAM.
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+-------------------------------------
//  s_axis  | in        | s_axis_tvalid / tready | tdata: value; tlast: end of sequence
//  m_axis  | out       | m_axis_tvalid / tready | tdata: pair_total, overflow
//
// A stored item takes popcount(value) query reads and one write for each Fenwick node
// on the update path; these always add up to VALUE_BITS+1, and a zero value skips
// the query. The single read and single write port of the tree RAM serialise them.
// A dropped item goes from idle straight to the finish state.
// After reset and after every 2**EPOCH_BITS sequences a clearing pass over all
// 2**VALUE_BITS tree words runs; input is not accepted during it.
// A held result stalls only the last item of the following sequence.
module non_strict_inversion_counter
    import nsic_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [9:0] value, [15:10] zero
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // [18:0] pair_total, [19] overflow
);

    localparam int NVAL   = 2 ** VALUE_BITS;
    localparam int IDX_W  = VALUE_BITS + 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int MEM_W  = EPOCH_BITS + CNT_W;
    localparam int SUM_W  = TOTAL_W + 1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_QRD, S_QACC, S_URD, S_UWR, S_FIN
    } t_state;

    t_state                  r_state, n_state;
    logic [VALUE_BITS-1:0]   r_val, n_val;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic [CNT_W-1:0]        r_acc, n_acc;
    logic [CNT_W-1:0]        r_seen, n_seen;
    logic [TOTAL_W-1:0]      r_pairs, n_pairs;
    logic                    r_drop, n_drop;
    logic                    r_last, n_last;
    logic [EPOCH_BITS-1:0]   r_epoch, n_epoch;
    logic [VALUE_BITS-1:0]   r_clr, n_clr;
    logic                    r_out_valid, n_out_valid;
    logic [TOTAL_W-1:0]      r_out_total, n_out_total;
    logic                    r_out_ovf, n_out_ovf;

    logic                    ram_we;
    logic [VALUE_BITS-1:0]   ram_waddr, ram_raddr;
    logic [MEM_W-1:0]        ram_wdata, ram_rdata;

    logic [VALUE_BITS+VALUE_W-1:0] val_ext;
    logic [VALUE_BITS-1:0]   in_val;
    logic [IDX_W-1:0]        low_bit, idx_down;
    logic [IDX_W:0]          idx_up;
    logic [CNT_W-1:0]        node_cnt, count_ge;
    logic [SUM_W-1:0]        pair_sum;
    logic                    in_accept, out_free;

    nsic_ram #(
        .WIDTH (MEM_W),
        .DEPTH (NVAL)
    ) u_tree (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign val_ext   = {{VALUE_BITS{1'b0}}, s_axis_tdata[VALUE_W-1:0]};
    assign in_val    = val_ext[VALUE_BITS-1:0];
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_out_valid || m_axis_tready;

    assign low_bit   = r_idx & (~r_idx + 1'b1);
    assign idx_down  = r_idx - low_bit;
    assign idx_up    = {1'b0, r_idx} + {1'b0, low_bit};
    assign node_cnt  = (ram_rdata[MEM_W-1 -: EPOCH_BITS] == r_epoch) ?
                       ram_rdata[CNT_W-1:0] : '0;
    assign count_ge  = r_seen - r_acc;
    assign pair_sum  = {1'b0, r_pairs} + {{(SUM_W-CNT_W){1'b0}}, count_ge};

    always_comb begin
        n_state     = r_state;
        n_val       = r_val;
        n_idx       = r_idx;
        n_acc       = r_acc;
        n_seen      = r_seen;
        n_pairs     = r_pairs;
        n_drop      = r_drop;
        n_last      = r_last;
        n_epoch     = r_epoch;
        n_clr       = r_clr;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_total = r_out_total;
        n_out_ovf   = r_out_ovf;
        ram_we      = 1'b0;
        ram_waddr   = r_idx[VALUE_BITS-1:0] - 1'b1;
        ram_wdata   = {r_epoch, node_cnt + 1'b1};
        ram_raddr   = r_idx[VALUE_BITS-1:0] - 1'b1;

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == VALUE_BITS'(NVAL - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_last = s_axis_tlast;
                    n_val  = in_val;
                    n_acc  = '0;
                    if (r_seen < CNT_W'(CAPACITY)) begin
                        if (in_val == '0) begin
                            n_idx   = IDX_W'(1);
                            n_state = S_URD;
                        end else begin
                            n_idx   = {1'b0, in_val};
                            n_state = S_QRD;
                        end
                    end else begin
                        n_drop  = 1'b1;
                        n_state = S_FIN;
                    end
                end
            end
            S_QRD: begin
                n_state = S_QACC;
            end
            S_QACC: begin
                n_acc     = r_acc + node_cnt;
                ram_raddr = idx_down[VALUE_BITS-1:0] - 1'b1;
                if (idx_down == '0) begin
                    n_idx   = {1'b0, r_val} + 1'b1;
                    n_state = S_URD;
                end else begin
                    n_idx   = idx_down;
                end
            end
            S_URD: begin
                n_seen = r_seen + 1'b1;
                if (pair_sum > {1'b0, TOTAL_MAX}) begin
                    n_pairs = TOTAL_MAX;
                end else begin
                    n_pairs = pair_sum[TOTAL_W-1:0];
                end
                n_state = S_UWR;
            end
            S_UWR: begin
                ram_we    = 1'b1;
                ram_raddr = idx_up[VALUE_BITS-1:0] - 1'b1;
                if (idx_up > (IDX_W+1)'(NVAL)) begin
                    n_state = S_FIN;
                end else begin
                    n_idx   = idx_up[IDX_W-1:0];
                end
            end
            S_FIN: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_total = r_pairs;
                    n_out_ovf   = r_drop;
                    n_seen      = '0;
                    n_pairs     = '0;
                    n_drop      = 1'b0;
                    n_epoch     = r_epoch + 1'b1;
                    n_clr       = '0;
                    if (r_epoch == {EPOCH_BITS{1'b1}}) begin
                        n_state = S_CLEAR;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_clr   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_seen      <= '0;
            r_pairs     <= '0;
            r_drop      <= 1'b0;
            r_last      <= 1'b0;
            r_epoch     <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seen      <= n_seen;
            r_pairs     <= n_pairs;
            r_drop      <= n_drop;
            r_last      <= n_last;
            r_epoch     <= n_epoch;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
        r_val       <= n_val;
        r_idx       <= n_idx;
        r_acc       <= n_acc;
        r_out_total <= n_out_total;
        r_out_ovf   <= n_out_ovf;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-TOTAL_W-1){1'b0}}, r_out_ovf, r_out_total};

    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= CNT_W'(CAPACITY))
        else $error("stored item count exceeds capacity");

    a_no_input_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !s_axis_tready)
        else $error("input accepted during clearing pass");

    a_no_write_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QRD || r_state == S_QACC) |-> !ram_we)
        else $error("tree written during prefix query");

    a_seq_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_last && out_free) |=> (r_seen == '0 && m_axis_tvalid))
        else $error("sequence end did not emit and clear");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Self-checking stream testbench for the non-strict inversion counter.
module testbench;
    import nsic_pkg::*;

    localparam int NVALUES = 1 << VALUE_BITS_DEF;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic               overflow;
    } t_seq_result;

    class t_nsic_scoreboard;
        int unsigned     value_hits [NVALUES];
        int unsigned     stored;
        longint unsigned pairs;
        bit              dropped;
        t_seq_result     awaited [$];
        int              failures;

        function new();
            failures = 0;
            clear_sequence();
        endfunction

        function void clear_sequence();
            foreach (value_hits[u]) value_hits[u] = 0;
            stored  = 0;
            pairs   = 0;
            dropped = 0;
        endfunction

        function void note_input(logic [VALUE_W-1:0] v, logic last);
            int unsigned idx;
            t_seq_result r;
            idx = v & (NVALUES - 1);
            if (stored < CAPACITY_DEF) begin
                for (int unsigned u = idx; u < NVALUES; u++) pairs += value_hits[u];
                if (pairs > TOTAL_MAX) pairs = TOTAL_MAX;
                value_hits[idx]++;
                stored++;
            end else begin
                dropped = 1;
            end
            if (last) begin
                r.total    = pairs[TOTAL_W-1:0];
                r.overflow = dropped;
                awaited = {awaited, r};
                clear_sequence();
            end
        endfunction

        function void complain(string what, longint want, longint got);
            failures++;
            if (failures <= 10)
                $display("%0t: mismatch in %s: expected %0d, actual %0d", $time, what, want, got);
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] d);
            t_seq_result want;
            if (awaited.size() == 0) begin
                complain("unexpected transaction, pair_total", -1, d[TOTAL_W-1:0]);
                return;
            end
            want = awaited.pop_front();
            if (d[TOTAL_W-1:0] !== want.total) complain("pair_total", want.total, d[TOTAL_W-1:0]);
            if (d[TOTAL_W] !== want.overflow) complain("overflow", want.overflow, d[TOTAL_W]);
        endfunction
    endclass

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tready = 1'b0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [OUT_DATA_W-1:0] m_tdata;

    int tx_idle_pct = 37;
    int rx_idle_pct = 37;

    t_nsic_scoreboard sb = new;

    non_strict_inversion_counter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),   // [9:0] value, [15:10] zero
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)    // [18:0] pair_total, [19] overflow
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
        if (i_rst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    task automatic send_value(input logic [VALUE_W-1:0] v, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W - VALUE_W){1'b0}}, v};
        s_tlast  <= last;
        do @(posedge i_clk); while (!s_tready);
        sb.note_input(v, last);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.awaited.size() != 0);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value(int mode, int base, int pos);
        case (mode)
            0:       return VALUE_W'($urandom());
            1:       return VALUE_W'(base + $urandom_range(3));
            2:       return VALUE_W'($urandom_range(3) * 341);
            default: return VALUE_W'(base - pos * $urandom_range(4));
        endcase
    endfunction

    initial begin
        logic [VALUE_W-1:0] seq [$];
        int sent;
        int len;
        int mode;
        int base;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        seq = '{10'd0};
        foreach (seq[k]) send_value(seq[k], k == seq.size() - 1);
        seq = '{10'd1023};
        foreach (seq[k]) send_value(seq[k], k == seq.size() - 1);
        seq = '{10'd1023, 10'd0, 10'd1023, 10'd0};
        foreach (seq[k]) send_value(seq[k], k == seq.size() - 1);
        seq = '{10'd5, 10'd5, 10'd5};
        foreach (seq[k]) send_value(seq[k], k == seq.size() - 1);
        seq = '{10'd1, 10'd2, 10'd4, 10'd8};
        foreach (seq[k]) send_value(seq[k], k == seq.size() - 1);
        seq = '{10'h155, 10'h2AA, 10'h155};
        foreach (seq[k]) send_value(seq[k], k == seq.size() - 1);
        seq = '{10'd1023, 10'd512, 10'd256, 10'd1};
        foreach (seq[k]) send_value(seq[k], k == seq.size() - 1);
        drain_results();

        // A full sequence of equal values gives the largest total without overflow.
        for (int k = 0; k < CAPACITY_DEF; k++) send_value(10'd7, k == CAPACITY_DEF - 1);
        // This one runs past capacity, so its last item is dropped yet still ends it.
        for (int k = 0; k < CAPACITY_DEF + 3; k++)
            send_value(VALUE_W'($urandom()), k == CAPACITY_DEF + 2);
        drain_results();

        sent = 0;
        while (sent < 800) begin
            if (sent >= 300 && sent < 450) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else begin
                tx_idle_pct = 37;
                rx_idle_pct = 37;
            end
            len  = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
            mode = $urandom_range(3);
            base = $urandom_range(1023);
            for (int k = 0; k < len; k++) send_value(pick_value(mode, base, k), k == len - 1);
            sent += len;
            if ($urandom_range(11) == 0) drain_results();
        end

        drain_results();
        repeat (100) @(posedge i_clk);
        if (sb.failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
hdl/nsic_pkg.sv
hdl/nsic_ram.sv
hdl/non_strict_inversion_counter.sv
tb/testbench.sv
